// ----- rtl/sfab_pkg.sv -----
// Shared types and constants for the shift/flip/logic blitter.
// Used by sfab_alu, the blitter core and the bench; depends on nothing else.
package sfab_pkg;

    localparam int ADDR_BITS = 13;

    typedef enum logic [1:0] {
        OP_CONTROL = 2'd0,
        OP_MAGIC   = 2'd1,
        OP_PLAIN   = 2'd2,
        OP_STATUS  = 2'd3
    } t_op;

    // logic function select, mode bits 7..4 (s = shifted byte, v = stored byte)
    typedef enum logic [3:0] {
        LF_S        = 4'd0,
        LF_S_OR_V   = 4'd1,
        LF_S_OR_NV  = 4'd2,
        LF_ONES     = 4'd3,
        LF_S_AND_V  = 4'd4,
        LF_V        = 4'd5,
        LF_XNOR     = 4'd6,
        LF_NS_OR_V  = 4'd7,
        LF_S_AND_NV = 4'd8,
        LF_XOR      = 4'd9,
        LF_NV       = 4'd10,
        LF_NAND     = 4'd11,
        LF_ZERO     = 4'd12,
        LF_NS_AND_V = 4'd13,
        LF_NOR      = 4'd14,
        LF_NS       = 4'd15
    } t_lfn;

    localparam logic [7:0] MODE_RESET = 8'hff;
    localparam logic [7:0] PREV_RESET = 8'hff;
    localparam int         MODE_FLIP  = 3;
    localparam logic [7:0] COLL_BIT   = 8'h80;

    typedef struct packed {
        t_op                  operation;
        logic [ADDR_BITS-1:0] address;
        logic [7:0]           data_byte;
        logic [7:0]           port_bits;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] stored_byte;
        logic       collision_flag;
    } t_res;

endpackage

// ----- rtl/sfab_store.sv -----
// Byte-wide video store: one write port, one read port, registered read data.
// No dependencies.
module sfab_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sfab_alu.sv -----
// Shift, optional bit reversal, collision test and logic combine for a magic write.
// Depends on sfab_pkg.
module sfab_alu (
    input  logic [7:0] i_mode,
    input  logic [7:0] i_prev,
    input  logic [7:0] i_data,
    input  logic [7:0] i_stored,
    output logic [7:0] o_result,
    output logic       o_hit
);

    logic [15:0] word;
    logic [15:0] shifted;
    logic [7:0]  s;
    logic [7:0]  v;
    logic [7:0]  s_flip;

    always_comb begin
        word    = {i_prev, i_data};
        // even part from bits 2..1 plus one from bit 0 is just bits 2..0
        shifted = word >> i_mode[2:0];
        for (int i = 0; i < 8; i++) begin
            s_flip[i] = shifted[7-i];
        end
        s = i_mode[sfab_pkg::MODE_FLIP] ? s_flip : shifted[7:0];
        v = i_stored;
        o_hit = |(s & v);
        case (sfab_pkg::t_lfn'(i_mode[7:4]))
            sfab_pkg::LF_S:        o_result = s;
            sfab_pkg::LF_S_OR_V:   o_result = s | v;
            sfab_pkg::LF_S_OR_NV:  o_result = s | ~v;
            sfab_pkg::LF_ONES:     o_result = 8'hff;
            sfab_pkg::LF_S_AND_V:  o_result = s & v;
            sfab_pkg::LF_V:        o_result = v;
            sfab_pkg::LF_XNOR:     o_result = ~(s ^ v);
            sfab_pkg::LF_NS_OR_V:  o_result = ~s | v;
            sfab_pkg::LF_S_AND_NV: o_result = s & ~v;
            sfab_pkg::LF_XOR:      o_result = s ^ v;
            sfab_pkg::LF_NV:       o_result = ~v;
            sfab_pkg::LF_NAND:     o_result = ~(s & v);
            sfab_pkg::LF_ZERO:     o_result = 8'h00;
            sfab_pkg::LF_NS_AND_V: o_result = ~s & v;
            sfab_pkg::LF_NOR:      o_result = ~(s | v);
            default:               o_result = ~s;
        endcase
    end

endmodule

// ----- rtl/shift_flip_alu_blitter_core.sv -----
// Blitter top level: request sequencer, mode/latch/collision registers,
// video store clearing pass. Depends on sfab_pkg, sfab_store and sfab_alu.
//
// For every request the store is read on the accepting edge and the modified
// byte is written back on the next, when the single result is presented on
// o_res for one cycle with o_res_valid high; busy drops in that same cycle so
// the next request can be accepted. A new request is not taken before the
// last is through, as the video store read is registered. After reset the
// store is swept to zero one byte a cycle, and busy stays high while all
// VIDEO_BYTES bytes (8192 at the default) are cleared, before the first
// request is taken. Results cannot be held off: o_res must be captured in the cycle o_res_valid is high.
module shift_flip_alu_blitter_core #(
    parameter int VIDEO_BYTES = 8192
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  sfab_pkg::t_req  i_req,
    output logic            o_res_valid,
    output sfab_pkg::t_res  o_res
);

    localparam int AW = $clog2(VIDEO_BYTES);
    localparam int CW = AW + 4;
    localparam logic [CW-1:0] VB   = CW'(VIDEO_BYTES);
    localparam logic [AW-1:0] LAST = AW'(VIDEO_BYTES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MODIFY
    } t_state;

    t_state          r_state;
    logic            r_busy;
    logic [AW-1:0]   r_clr_idx;
    logic [AW-1:0]   r_idx;
    sfab_pkg::t_req  r_req;
    logic [7:0]      r_mode;
    logic [7:0]      r_prev;
    logic            r_coll;
    sfab_pkg::t_res  r_res;
    logic            r_res_valid;

    logic [CW-1:0]   n_wrap;
    logic [AW-1:0]   n_idx;
    sfab_pkg::t_res  n_res;
    logic            n_coll;
    logic            accept;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic [7:0]      mem_rdata;
    logic [7:0]      alu_result;
    logic            alu_hit;

    assign accept = (r_state == S_IDLE) && start && !r_busy;

    // address wrap: quotient is below eight, so three restoring steps do it
    always_comb begin
        n_wrap = CW'(i_req.address);
        for (int k = 2; k >= 0; k--) begin
            if (n_wrap >= (VB << k)) begin
                n_wrap = n_wrap - (VB << k);
            end
        end
        n_idx = n_wrap[AW-1:0];
    end

    sfab_alu u_alu (
        .i_mode   (r_mode),
        .i_prev   (r_prev),
        .i_data   (r_req.data_byte),
        .i_stored (mem_rdata),
        .o_result (alu_result),
        .o_hit    (alu_hit)
    );

    always_comb begin
        n_res  = '0;
        n_coll = r_coll;
        case (r_req.operation)
            sfab_pkg::OP_CONTROL: begin
                n_coll = 1'b0;
            end
            sfab_pkg::OP_MAGIC: begin
                n_coll            = r_coll | alu_hit;
                n_res.stored_byte = alu_result;
            end
            sfab_pkg::OP_PLAIN: begin
                n_res.stored_byte = r_req.data_byte;
            end
            default: begin
                n_res.read_data = r_req.port_bits | (r_coll ? sfab_pkg::COLL_BIT : 8'h00);
            end
        endcase
        n_res.collision_flag = n_coll;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = n_res.stored_byte;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = 8'h00;
        end else if (r_state == S_MODIFY) begin
            mem_we = (r_req.operation == sfab_pkg::OP_MAGIC) ||
                     (r_req.operation == sfab_pkg::OP_PLAIN);
        end
    end

    sfab_store #(
        .DEPTH (VIDEO_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (n_idx),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_busy      <= 1'b1;
            r_clr_idx   <= '0;
            r_mode      <= sfab_pkg::MODE_RESET;
            r_prev      <= sfab_pkg::PREV_RESET;
            r_coll      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_res_valid <= 1'b0;
                    r_clr_idx   <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LAST) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    r_res_valid <= 1'b0;
                    if (accept) begin
                        r_req   <= i_req;
                        r_idx   <= n_idx;
                        r_state <= S_MODIFY;
                        r_busy  <= 1'b1;
                    end
                end
                S_MODIFY: begin
                    r_res       <= n_res;
                    r_res_valid <= 1'b1;
                    r_coll      <= n_coll;
                    if (r_req.operation == sfab_pkg::OP_CONTROL) begin
                        r_mode <= r_req.data_byte;
                        r_prev <= 8'h00;
                    end else if (r_req.operation == sfab_pkg::OP_MAGIC) begin
                        r_prev <= r_req.data_byte;
                    end
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_res_valid <= 1'b0;
                    r_state     <= S_IDLE;
                    r_busy      <= 1'b0;
                end
            endcase
        end
    end

    assign busy        = r_busy;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // a request accepted while idle always returns its result, registered in the modify state
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_res_valid)
        else $error("result missing two cycles after request");

    // the result cycle is also the cycle a new request may be taken
    a_free_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("busy high while result presented");

    // collision only clears through a control write
    a_coll_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_coll) |->
            $past(r_state == S_MODIFY && r_req.operation == sfab_pkg::OP_CONTROL))
        else $error("collision flag cleared without control write");

    // a status read with nonzero read data reports no stored byte
    a_status_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.read_data != 8'h00) |-> (o_res.stored_byte == 8'h00))
        else $error("status read reported a stored byte");

endmodule

// ----- verif/tb_shift_flip_alu_blitter_core.sv -----
// Self-checking bench for shift_flip_alu_blitter_core: directed and random request
// streams against a behavioural model of the mode, latch, collision and video store.
// Depends on sfab_pkg and the RTL under rtl; needs no files or arguments.
module tb_shift_flip_alu_blitter_core;
    import sfab_pkg::*;

    localparam int VIDEO_BYTES  = 8192;
    localparam int CYCLE_LIMIT  = 120000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int IDLE_PCT     = 18;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_res_valid;
    t_res o_res;

    // model state
    logic [7:0] mode_reg;
    logic [7:0] latch_reg;
    logic       coll_reg;
    logic [7:0] video_model [VIDEO_BYTES];

    t_res pending_results [$];
    int   op_count [4];
    int   checked_results;
    int   fail_count;
    int   cycle_count;
    bit   idle_enabled;

    shift_flip_alu_blitter_core #(
        .VIDEO_BYTES(VIDEO_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] flip_byte(logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = b[i];
        end
        return r;
    endfunction

    function automatic logic [7:0] logic_fn(t_lfn f, logic [7:0] s, logic [7:0] v);
        case (f)
            LF_S:        return s;
            LF_S_OR_V:   return s | v;
            LF_S_OR_NV:  return s | ~v;
            LF_ONES:     return 8'hff;
            LF_S_AND_V:  return s & v;
            LF_V:        return v;
            LF_XNOR:     return ~(s ^ v);
            LF_NS_OR_V:  return ~s | v;
            LF_S_AND_NV: return s & ~v;
            LF_XOR:      return s ^ v;
            LF_NV:       return ~v;
            LF_NAND:     return ~(s & v);
            LF_ZERO:     return 8'h00;
            LF_NS_AND_V: return ~s & v;
            LF_NOR:      return ~(s | v);
            default:     return ~s;
        endcase
    endfunction

    // updates the model state and returns the result the request should produce
    function automatic t_res blit_predict(t_req r);
        t_res       res;
        logic [15:0] word;
        logic [15:0] shifted;
        logic [3:0]  sh;
        logic [7:0]  src;
        logic [7:0]  dst;
        int          idx;
        res = '0;
        idx = int'(r.address) % VIDEO_BYTES;
        case (r.operation)
            OP_CONTROL: begin
                mode_reg  = r.data_byte;
                latch_reg = 8'h00;
                coll_reg  = 1'b0;
            end
            OP_MAGIC: begin
                word    = {latch_reg, r.data_byte};
                sh      = {1'b0, mode_reg[2:1], 1'b0} + {3'b000, mode_reg[0]};
                shifted = word >> sh;
                src     = shifted[7:0];
                if (mode_reg[MODE_FLIP])
                    src = flip_byte(src);
                dst       = video_model[idx];
                latch_reg = r.data_byte;
                if ((src & dst) != 8'h00)
                    coll_reg = 1'b1;
                res.stored_byte  = logic_fn(t_lfn'(mode_reg[7:4]), src, dst);
                video_model[idx] = res.stored_byte;
            end
            OP_PLAIN: begin
                res.stored_byte  = r.data_byte;
                video_model[idx] = r.data_byte;
            end
            default: begin
                res.read_data = r.port_bits | (coll_reg ? COLL_BIT : 8'h00);
            end
        endcase
        res.collision_flag = coll_reg;
        return res;
    endfunction

    function automatic t_req mk_req(t_op op, logic [ADDR_BITS-1:0] addr,
                                    logic [7:0] data, logic [7:0] port);
        t_req r;
        r.operation = op;
        r.address   = addr;
        r.data_byte = data;
        r.port_bits = port;
        return r;
    endfunction

    // called just after a rising edge; drives at the falling edge, returns on acceptance
    task automatic send_request(t_req r);
        int gap;
        @(negedge i_clk);
        if (idle_enabled && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(blit_predict(r));
        op_count[r.operation]++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : res_check
        t_res want;
        if (i_rst_n === 1'b1 && o_res_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %h", o_res);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                checked_results++;
                if (o_res.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, o_res.read_data);
                    fail_count++;
                end
                if (o_res.stored_byte !== want.stored_byte) begin
                    $error("stored_byte: expected %h, got %h",
                           want.stored_byte, o_res.stored_byte);
                    fail_count++;
                end
                if (o_res.collision_flag !== want.collision_flag) begin
                    $error("collision_flag: expected %b, got %b",
                           want.collision_flag, o_res.collision_flag);
                    fail_count++;
                end
            end
        end
    end

    // status after the clearing pass, then a magic write with reset mode and latch
    task automatic test_reset_state();
        send_request(mk_req(OP_STATUS, 13'h1555, 8'h00, 8'h00));
        send_request(mk_req(OP_STATUS, 13'h0aaa, 8'hff, 8'h7f));
        send_request(mk_req(OP_MAGIC, 13'h0000, 8'ha5, 8'h80));
    endtask

    task automatic test_plain_write();
        send_request(mk_req(OP_PLAIN, 13'h0000, 8'hff, 8'h00));
        send_request(mk_req(OP_PLAIN, 13'h1fff, 8'h3c, 8'hff));
        send_request(mk_req(OP_PLAIN, 13'h0aaa, 8'h5a, 8'h55));
    endtask

    // one mode per function; shift amount and flip ride along on the same mode byte
    task automatic test_logic_shift_flip();
        logic [3:0] f;
        for (int i = 0; i < 16; i++) begin
            f = 4'(i);
            send_request(mk_req(OP_CONTROL, 13'(i * 397), {f, f[3], f[2:0]}, 8'(i)));
            send_request(mk_req(OP_MAGIC, f[0] ? 13'h1fff : 13'h0000,
                                8'($urandom_range(255)), 8'h00));
        end
    endtask

    // collision is sticky across plain writes and cleared only by a control write
    task automatic test_collision_sticky();
        send_request(mk_req(OP_CONTROL, 13'h0000, {LF_S_OR_V, 4'h0}, 8'h00));
        send_request(mk_req(OP_PLAIN, 13'h0005, 8'h0f, 8'h00));
        send_request(mk_req(OP_MAGIC, 13'h0005, 8'h01, 8'h00));
        send_request(mk_req(OP_PLAIN, 13'h0005, 8'h00, 8'h00));
        send_request(mk_req(OP_STATUS, 13'h1fff, 8'h00, 8'h00));
        send_request(mk_req(OP_CONTROL, 13'h1234, {LF_XOR, 4'h0}, 8'h00));
        send_request(mk_req(OP_STATUS, 13'h0000, 8'h00, 8'h00));
    endtask

    // mostly blit rows: a mode write then a run of magic writes over a small window
    task automatic test_random_blits();
        int                   sent;
        int                   run_len;
        logic [ADDR_BITS-1:0] base;
        int                   pick;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_enabled = !(sent >= 500 && sent < 800);
            if (sent >= 700 && sent < 720)
                wait_drained();
            if ($urandom_range(99) < 75) begin
                base = ($urandom_range(99) < 15) ? ADDR_BITS'($urandom)
                                                 : ADDR_BITS'($urandom_range(255));
                send_request(mk_req(OP_CONTROL, ADDR_BITS'($urandom),
                                    8'($urandom), 8'($urandom)));
                sent++;
                run_len = $urandom_range(2, 12);
                for (int k = 0; k < run_len; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 10)
                        send_request(mk_req(OP_STATUS, ADDR_BITS'($urandom),
                                            8'($urandom), 8'($urandom)));
                    else if (pick < 20)
                        send_request(mk_req(OP_PLAIN, base + ADDR_BITS'($urandom_range(15)),
                                            8'($urandom), 8'($urandom)));
                    else
                        send_request(mk_req(OP_MAGIC, base + ADDR_BITS'(k),
                                            8'($urandom), 8'($urandom)));
                    sent++;
                end
                send_request(mk_req(OP_STATUS, ADDR_BITS'($urandom),
                                    8'($urandom), 8'($urandom)));
                sent++;
            end else begin
                send_request(mk_req(t_op'($urandom_range(3)), ADDR_BITS'($urandom),
                                    8'($urandom), 8'($urandom)));
                sent++;
            end
            if (sent >= 700 && sent < 720) begin
                wait_drained();
                sent = 720;
            end
        end
        idle_enabled = 1'b1;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_req           = '0;
        mode_reg        = MODE_RESET;
        latch_reg       = PREV_RESET;
        coll_reg        = 1'b0;
        checked_results = 0;
        fail_count      = 0;
        cycle_count     = 0;
        idle_enabled    = 1'b1;
        foreach (op_count[i]) op_count[i] = 0;
        foreach (video_model[i]) video_model[i] = 8'h00;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_plain_write();
        test_logic_shift_flip();
        test_collision_sticky();
        wait_drained();
        test_random_blits();

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("covered %0d requests: %0d control, %0d magic, %0d plain, %0d status",
                 op_count[OP_CONTROL] + op_count[OP_MAGIC] + op_count[OP_PLAIN]
                 + op_count[OP_STATUS], op_count[OP_CONTROL], op_count[OP_MAGIC],
                 op_count[OP_PLAIN], op_count[OP_STATUS]);
        $display("%0d results checked field by field, %0d mismatches",
                 checked_results, fail_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
